@@ rtl/jsu_pkg.sv @@
// Shared types, codes and helpers for the JSON string unescape unit.
`timescale 1ns / 1ps

package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_HEX      = 3'd2;
    localparam logic [2:0] ERR_CONTROL  = 3'd3;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd4;

    // Characters the parser reacts to
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_MAX  = 8'd31;

    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST  = 16'hdbff;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;
    localparam logic [15:0] LOW_LAST   = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam int MaxBytes = 4;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_BODY    = 7'b0000010,
        PH_ESC     = 7'b0000100,
        PH_HEX     = 7'b0001000,
        PH_WAIT_BS = 7'b0010000,
        PH_WAIT_U  = 7'b0100000,
        PH_HEX_LOW = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  digits;
        logic [15:0] high_unit;
        logic [15:0] hex_accum;
    } state_t;

    // Up to four words from one input byte; kind/err apply to all of them
    typedef struct packed {
        logic [2:0]                count;
        logic [MaxBytes-1:0][7:0]  bytes;
        logic [1:0]                kind;
        logic [2:0]                err;
    } result_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic result_t utf8_encode(input logic [20:0] cp);
        result_t r;
        r = '0;
        r.kind = KIND_DATA;
        r.err  = ERR_NONE;
        if (cp < 21'h80) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/json_string_unescape_unit.sv @@
// Top level of the JSON string unescape unit: input register, parser state, result buffer.
`timescale 1ns / 1ps

// Channel  Dir  tdata            tuser                      tlast
// s_*      in   [7:0] in_byte    restart                    end_of_text
// m_*      out  [7:0] out_byte   [1:0] kind, [4:2] err code last word of the byte
//
// A byte is registered in the input register, decoded there and its words go to the result
// buffer that drives m_*. One byte per cycle while each yields at most one word and m_tready
// is high; a \u escape that decodes to several UTF-8 bytes holds the input while the buffer
// drains. Reset clears the input register, the result buffer and puts the parser idle
// (awaiting a restart byte). Back pressure on m_tready stalls decoding and then s_tready.

module json_string_unescape_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tuser,    // restart
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [4:0] m_tuser,    // [1:0] kind, [4:2] error_code
    output logic       m_tlast     // last word caused by the input byte
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_restart_reg;
    logic             in_eot_reg;

    jsu_pkg::state_t  state_reg;
    jsu_pkg::state_t  state_next;
    jsu_pkg::result_t res;

    logic             buf_ready;
    logic             proc_fire;
    logic             s_fire;

    jsu_decode u_decode (
        .cur     (state_reg),
        .in_byte (in_byte_reg),
        .restart (in_restart_reg),
        .eot     (in_eot_reg),
        .nxt     (state_next),
        .res     (res)
    );

    // bytes that produce no word never wait on the buffer
    assign proc_fire = in_valid_reg && (res.count == 3'd0 || buf_ready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_fire)
            in_valid_reg <= 1'b1;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
            in_eot_reg     <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= jsu_pkg::PH_IDLE;
            state_reg.digits    <= 2'd0;
            state_reg.high_unit <= 16'd0;
            state_reg.hex_accum <= 16'd0;
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
        end
    end

    jsu_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc_fire && res.count != 3'd0),
        .res      (res),
        .ready    (buf_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_status_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && res.count != 3'd0 && res.kind != jsu_pkg::KIND_DATA)
            |=> state_reg.phase == jsu_pkg::PH_IDLE)
        else $error("parser not idle after done or error");

    a_restart_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_restart_reg && res.count == 3'd0)
            |=> state_reg.phase != jsu_pkg::PH_IDLE)
        else $error("restart byte without result left parser idle");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_restart_reg && state_reg.phase == jsu_pkg::PH_IDLE)
            |-> res.count == 3'd0)
        else $error("idle parser produced a result");

endmodule

@@ rtl/jsu_decode.sv @@
// Next-state and result logic for one string body byte.
`timescale 1ns / 1ps

module jsu_decode (
    input  jsu_pkg::state_t  cur,
    input  logic [7:0]       in_byte,
    input  logic             restart,
    input  logic             eot,
    output jsu_pkg::state_t  nxt,
    output jsu_pkg::result_t res
);

    jsu_pkg::state_t base;
    logic [4:0]      hex;
    logic [15:0]     acc_new;
    logic [20:0]     pair_cp;

    always_comb
    begin
        base = cur;
        if (restart)
        begin
            base.phase     = jsu_pkg::PH_BODY;
            base.digits    = 2'd0;
            base.high_unit = 16'd0;
            base.hex_accum = 16'd0;
        end
    end

    assign hex     = jsu_pkg::hex_digit(in_byte);
    assign acc_new = {base.hex_accum[11:0], hex[3:0]};
    // 0x10000 + (high - 0xd800) << 10 + (low - 0xdc00)
    assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, base.high_unit[9:0], acc_new[9:0]};

    always_comb
    begin
        nxt      = base;
        res      = '0;
        res.kind = jsu_pkg::KIND_DATA;
        res.err  = jsu_pkg::ERR_NONE;
        unique case (base.phase)
            jsu_pkg::PH_BODY:
            begin
                if (eot)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_NO_QUOTE;
                end
                else if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_DONE;
                end
                else if (in_byte == jsu_pkg::CH_BSLASH)
                begin
                    nxt.phase = jsu_pkg::PH_ESC;
                end
                else if (in_byte <= jsu_pkg::CTRL_MAX)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_CONTROL;
                end
                else
                begin
                    res.count    = 3'd1;
                    res.bytes[0] = in_byte;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                nxt.phase = jsu_pkg::PH_BODY;
                res.count = 3'd1;
                if (eot)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_ESCAPE;
                end
                else
                begin
                    unique case (in_byte)
                        jsu_pkg::CH_B: res.bytes[0] = 8'h08;
                        jsu_pkg::CH_F: res.bytes[0] = 8'h0c;
                        jsu_pkg::CH_N: res.bytes[0] = 8'h0a;
                        jsu_pkg::CH_R: res.bytes[0] = 8'h0d;
                        jsu_pkg::CH_T: res.bytes[0] = 8'h09;
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSLASH:
                            res.bytes[0] = in_byte;
                        jsu_pkg::CH_U:
                        begin
                            nxt.phase     = jsu_pkg::PH_HEX;
                            nxt.digits    = 2'd0;
                            nxt.hex_accum = 16'd0;
                            res.count     = 3'd0;
                        end
                        default:
                        begin
                            nxt.phase = jsu_pkg::PH_IDLE;
                            res.kind  = jsu_pkg::KIND_ERR;
                            res.err   = jsu_pkg::ERR_ESCAPE;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEX, jsu_pkg::PH_HEX_LOW:
            begin
                if (eot || !hex[4])
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_HEX;
                end
                else
                begin
                    nxt.hex_accum = acc_new;
                    if (base.digits != 2'd3)
                    begin
                        nxt.digits = base.digits + 2'd1;
                    end
                    else
                    begin
                        nxt.digits = 2'd0;
                        if (base.phase == jsu_pkg::PH_HEX)
                        begin
                            if (acc_new >= jsu_pkg::HIGH_FIRST && acc_new <= jsu_pkg::HIGH_LAST)
                            begin
                                nxt.high_unit = acc_new;
                                nxt.phase     = jsu_pkg::PH_WAIT_BS;
                            end
                            else
                            begin
                                nxt.phase = jsu_pkg::PH_BODY;
                                res       = jsu_pkg::utf8_encode({5'd0, acc_new});
                            end
                        end
                        else if (acc_new < jsu_pkg::LOW_FIRST || acc_new > jsu_pkg::LOW_LAST)
                        begin
                            nxt.phase = jsu_pkg::PH_IDLE;
                            res.count = 3'd1;
                            res.kind  = jsu_pkg::KIND_ERR;
                            res.err   = jsu_pkg::ERR_HEX;
                        end
                        else
                        begin
                            nxt.phase = jsu_pkg::PH_BODY;
                            res       = jsu_pkg::utf8_encode(pair_cp);
                        end
                    end
                end
            end
            jsu_pkg::PH_WAIT_BS:
            begin
                if (eot || in_byte != jsu_pkg::CH_BSLASH)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_HEX;
                end
                else
                begin
                    nxt.phase = jsu_pkg::PH_WAIT_U;
                end
            end
            jsu_pkg::PH_WAIT_U:
            begin
                if (eot || in_byte != jsu_pkg::CH_U)
                begin
                    nxt.phase = jsu_pkg::PH_IDLE;
                    res.count = 3'd1;
                    res.kind  = jsu_pkg::KIND_ERR;
                    res.err   = jsu_pkg::ERR_HEX;
                end
                else
                begin
                    nxt.phase     = jsu_pkg::PH_HEX_LOW;
                    nxt.digits    = 2'd0;
                    nxt.hex_accum = 16'd0;
                end
            end
            default:
            begin
                // idle (or a corrupt code): byte dropped without result
                nxt.phase = jsu_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/jsu_obuf.sv @@
// Result register that plays out up to four words of one decoded byte.
`timescale 1ns / 1ps

module jsu_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::result_t res,
    output logic             ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [4:0]       m_tuser,   // [1:0] kind, [4:2] error_code
    output logic             m_tlast    // last word of this input byte
);

    logic                                  valid_reg;
    logic [1:0]                            idx_reg;
    logic [2:0]                            cnt_reg;
    logic [jsu_pkg::MaxBytes-1:0][7:0]     bytes_reg;
    logic [1:0]                            kind_reg;
    logic [2:0]                            err_reg;
    logic                                  at_last;
    logic                                  out_fire;

    assign at_last  = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign out_fire = valid_reg && m_tready;
    assign ready    = !valid_reg || (m_tready && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            cnt_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
            cnt_reg   <= res.count;
        end
        else if (out_fire)
        begin
            if (at_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            kind_reg  <= res.kind;
            err_reg   <= res.err;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tuser  = {err_reg, kind_reg};
    assign m_tlast  = at_last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cnt_reg != 3'd0 && cnt_reg <= 3'd4))
        else $error("result count out of range");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != jsu_pkg::KIND_DATA) |-> (cnt_reg == 3'd1 && at_last))
        else $error("done or error result spans more than one word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (m_tready && at_last)))
        else $error("result register overwritten before drained");

endmodule
